// File: rtl/btda_pkg.sv
package btda_pkg;

  // Widths of the input and result fields.
  localparam int VALUE_W = 32;
  localparam int PAD_W   = 5;
  localparam int CHAR_W  = 6;

  // A 32-bit value has at most ten decimal digits.
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * 4;

  // Bits of the shift counter in the converter.
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // Converter to emitter: a finished conversion and its pad width.
  typedef struct packed {
    logic             valid;
    logic [PAD_W-1:0] pad;
    bcd_t             bcd;
  } conv_res_t;

  // Double-dabble correction of one digit before the shift.
  function automatic logic [3:0] add3(input logic [3:0] d);
    add3 = (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

// File: rtl/btda_conv.sv
module btda_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [btda_pkg::VALUE_W-1:0]  value,
  input  logic [btda_pkg::PAD_W-1:0]    pad,
  output logic                          busy,
  output btda_pkg::conv_res_t           res
);
  import btda_pkg::*;

  typedef enum logic [1:0] {
    CV_IDLE  = 2'b01,
    CV_SHIFT = 2'b10
  } conv_state_t;

  conv_state_t             state_r, state_nxt;
  logic [VALUE_W-1:0]      bin_r, bin_nxt;
  bcd_t                    bcd_r, bcd_nxt;
  logic [SHIFT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PAD_W-1:0]        pad_r, pad_nxt;
  logic                    done_r, done_nxt;
  bcd_t                    adj;
  logic [BCD_W-1:0]        adj_flat;

  // Correct every digit, then the shift moves one binary bit into the BCD word.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = add3(bcd_r[i]);
    end
  end

  assign adj_flat = adj;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      CV_IDLE: begin
        if (load) begin
          bin_nxt   = value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          pad_nxt   = pad;
          state_nxt = CV_SHIFT;
        end
      end
      CV_SHIFT: begin
        bcd_nxt = bcd_t'({adj_flat[BCD_W-2:0], bin_r[VALUE_W-1]});
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SHIFT_CNT_W'(VALUE_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = CV_IDLE;
        end
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    pad_r <= pad_nxt;
  end

  assign busy      = (state_r == CV_SHIFT) || done_r;
  assign res.valid = done_r;
  assign res.pad   = pad_r;
  assign res.bcd   = bcd_r;

endmodule

// File: rtl/btda_emit.sv
module btda_emit #(
  parameter int MAX_WIDTH = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btda_pkg::conv_res_t          res,
  output logic                         busy,
  output logic                         out_valid,
  output logic [btda_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                         out_last
);
  import btda_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH);
  localparam logic [5:0] LIMIT = 6'((MAX_WIDTH > 32) ? 32 : MAX_WIDTH);

  typedef enum logic [1:0] {
    EM_IDLE = 2'b01,
    EM_RUN  = 2'b10
  } emit_state_t;

  emit_state_t         state_r, state_nxt;
  bcd_t                bcd_r, bcd_nxt;
  logic [IDX_W-1:0]    place_r, place_nxt;
  logic                valid_r, valid_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [5:0]          sig;
  logic [5:0]          width;
  logic [3:0]          digit;

  // Count of significant digits, at least one for a zero value.
  always_comb begin
    sig = 6'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (res.bcd[i] != 4'd0) sig = 6'(i + 1);
    end
    width = (res.pad == '0) ? sig : 6'(res.pad);
    if (width > LIMIT) width = LIMIT;
  end

  // Places above the tenth digit are always zero.
  assign digit = (place_r < IDX_W'(NUM_DIGITS)) ? bcd_r[place_r[3:0]] : 4'd0;

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    place_nxt = place_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    unique case (state_r)
      EM_IDLE: begin
        if (res.valid) begin
          bcd_nxt   = res.bcd;
          place_nxt = IDX_W'(width - 6'd1);
          state_nxt = EM_RUN;
        end
      end
      EM_RUN: begin
        valid_nxt = 1'b1;
        char_nxt  = ASCII_ZERO + CHAR_W'(digit);
        last_nxt  = (place_r == '0);
        if (place_r == '0) begin
          state_nxt = EM_IDLE;
        end else begin
          place_nxt = place_r - 1'b1;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    bcd_r   <= bcd_nxt;
    place_r <= place_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign busy           = (state_r == EM_RUN);
  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last       = last_r;

endmodule

// File: rtl/binary_to_decimal_ascii_top.sv
// Channel   Handshake                 Fields
// input     start & !busy             in_value[31:0], in_pad_width[4:0]
// result    out_valid, one cycle      out_digit_char[5:0], out_last
//
// A word is first converted by double-dabble shifting, one bit per cycle,
// then its digits are emitted, most significant place first; the last
// digit is on the result ports in the same cycle that busy drops.
// Reset is synchronous and active low; it clears the control state only.
// Results are never held back: each digit is shown for one cycle.
module binary_to_decimal_ascii_top #(
  parameter int MAX_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [btda_pkg::VALUE_W-1:0]  in_value,
  input  logic [btda_pkg::PAD_W-1:0]    in_pad_width,
  output logic                          out_valid,
  output logic [btda_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last
);
  import btda_pkg::*;

  conv_res_t res;
  logic      conv_busy;
  logic      emit_busy;

  // Binary to BCD conversion.
  btda_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (start && !busy),
    .value (in_value),
    .pad   (in_pad_width),
    .busy  (conv_busy),
    .res   (res)
  );

  // Digit emission, most significant place first.
  btda_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .busy           (emit_busy),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  assign busy = conv_busy || emit_busy;

endmodule
